### rtl/calendar_date_stepper_defines.svh
// Assertion macros shared by the calendar date stepper RTL.
`ifndef CALENDAR_DATE_STEPPER_DEFINES_SVH
`define CALENDAR_DATE_STEPPER_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define CDS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define CDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cds_pkg.sv
// Types, constants and calendar helper functions for the calendar date stepper.
package cds_pkg;

  // Year limits and reset date
  localparam logic [13:0] YearMin   = 14'd1900;
  localparam logic [13:0] YearMax   = 14'd9999;
  localparam logic [4:0]  ResetDay  = 5'd1;
  localparam logic [3:0]  ResetMon  = 4'd1;
  localparam logic [6:0]  ResetYy   = 7'd0;
  localparam logic [6:0]  ResetCc   = 7'd19;

  // Largest accepted day count magnitude
  localparam int MaxDelta = 4096;

  // Divide by 100 through a reciprocal multiply (exact for 14-bit years)
  localparam int Div100Mul   = 5243;
  localparam int Div100Shift = 19;

  // Zeller sum offset: +5 for Monday = 0, +175 (a multiple of 7) to stay non-negative
  localparam logic [9:0] WdayBias = 10'd180;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_ADD  = 1'b1
  } cds_req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_DIV,
    ST_LOAD_REM,
    ST_ADD_INIT,
    ST_WALK,
    ST_CHECK,
    ST_WDAY,
    ST_DONE
  } cds_state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic load_div;
    logic load_rem;
    logic add_init;
    logic walk;
    logic check;
    logic wday;
    logic out_load;
  } cds_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_done;
    logic delta_bad;
  } cds_stat_t;

  // Leap rule on a year split into century and year of century
  function automatic logic is_leap(input logic [1:0] ylo, input logic [6:0] yy,
                                   input logic [6:0] cc);
    return (ylo == 2'd0) && ((yy != 7'd0) || (cc[1:0] == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // floor(13 * (m' + 1) / 5) with January and February as months 13 and 14
  function automatic logic [5:0] zeller_mterm(input logic [3:0] m);
    logic [5:0] t;
    case (m)
      4'd1:    t = 6'd36;
      4'd2:    t = 6'd39;
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  // Modulo 7 of a 9-bit value by folding octal digits (8 = 1 mod 7)
  function automatic logic [2:0] mod7(input logic [8:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(x[8:6]) + 5'(x[5:3]) + 5'(x[2:0]);
    s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

endpackage

### rtl/cds_req_if.sv
// Request channel: valid/ready handshake with load and add payload.
interface cds_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [4:0]         load_day;
  logic [3:0]         load_month;
  logic [13:0]        load_year;
  logic signed [13:0] day_delta;

  modport source (
    output valid, req_type, load_day, load_month, load_year, day_delta,
    input  ready
  );
  modport sink (
    input  valid, req_type, load_day, load_month, load_year, day_delta,
    output ready
  );
endinterface

### rtl/cds_rsp_if.sv
// Response channel: valid/ready handshake with status, date and weekday.
interface cds_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [4:0]  out_day;
  logic [3:0]  out_month;
  logic [13:0] out_year;
  logic [2:0]  weekday;

  modport source (
    output valid, ok, out_day, out_month, out_year, weekday,
    input  ready
  );
  modport sink (
    input  valid, ok, out_day, out_month, out_year, weekday,
    output ready
  );
endinterface

### rtl/cds_ctrl.sv
// Controller state machine: sequences load, month walk, check and weekday steps.
`include "calendar_date_stepper_defines.svh"

module cds_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_req_type_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  cds_pkg::cds_stat_t stat_i,
  output cds_pkg::cds_cmd_t  cmd_o
);
  import cds_pkg::*;

  cds_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (cds_req_e'(in_req_type_i))
            REQ_LOAD: state_d = ST_LOAD_DIV;
            REQ_ADD:  state_d = ST_ADD_INIT;
            default:  state_d = ST_ADD_INIT;
          endcase
        end
      end
      ST_LOAD_DIV: state_d = ST_LOAD_REM;
      ST_LOAD_REM: state_d = ST_CHECK;
      ST_ADD_INIT: state_d = stat_i.delta_bad ? ST_WDAY : ST_WALK;
      ST_WALK:     state_d = stat_i.walk_done ? ST_CHECK : ST_WALK;
      ST_CHECK:    state_d = ST_WDAY;
      ST_WDAY:     state_d = ST_DONE;
      ST_DONE:     state_d = out_free ? ST_IDLE : ST_DONE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_LOAD_DIV: cmd_o.load_div = 1'b1;
      ST_LOAD_REM: cmd_o.load_rem = 1'b1;
      ST_ADD_INIT: cmd_o.add_init = 1'b1;
      ST_WALK:     cmd_o.walk     = 1'b1;
      ST_CHECK:    cmd_o.check    = 1'b1;
      ST_WDAY:     cmd_o.wday     = 1'b1;
      ST_DONE:     cmd_o.out_load = out_free;
      default:     cmd_o          = '0;
    endcase
  end

  // Response valid: set on load, cleared when the transaction completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `CDS_ASSERT_NXT(a_accept_branch, in_valid_i && (state_q == ST_IDLE), (state_q == ST_LOAD_DIV) || (state_q == ST_ADD_INIT), "accepted request did not start a load or add")
  `CDS_ASSERT_IMP(a_no_overwrite, cmd_o.out_load, !out_valid_q || out_ready_i, "pending response overwritten")
  `CDS_ASSERT_IMP(a_rsp_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE, "response raised outside the done step")

endmodule

### rtl/cds_dpath.sv
// Datapath: date registers, year split, month walk, validity check, weekday.
`include "calendar_date_stepper_defines.svh"

module cds_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cds_pkg::cds_cmd_t  cmd_i,
  output cds_pkg::cds_stat_t stat_o,
  input  logic [4:0]         load_day_i,
  input  logic [3:0]         load_month_i,
  input  logic [13:0]        load_year_i,
  input  logic signed [13:0] day_delta_i,
  output logic               ok_o,
  output logic [4:0]         out_day_o,
  output logic [3:0]         out_month_o,
  output logic [13:0]        out_year_o,
  output logic [2:0]         weekday_o
);
  import cds_pkg::*;

  // Captured request
  logic [4:0]         ld_day_q;
  logic [3:0]         ld_mon_q;
  logic [13:0]        ld_yr_q;
  logic signed [13:0] delta_q;

  // Working date
  logic signed [14:0] wd_q;
  logic [3:0]         wm_q;
  logic [13:0]        wy_q;
  logic [6:0]         wyy_q, wcc_q;
  logic [7:0]         q100_q;

  // Held date
  logic [4:0]  cur_day_q;
  logic [3:0]  cur_mon_q;
  logic [13:0] cur_yr_q;
  logic [6:0]  cur_yy_q, cur_cc_q;

  logic        ok_q;
  logic [8:0]  wx_q;

  // Response register
  logic        rsp_ok_q;
  logic [4:0]  rsp_day_q;
  logic [3:0]  rsp_mon_q;
  logic [13:0] rsp_yr_q;
  logic [2:0]  rsp_wday_q;

  logic [26:0]        prod100;
  logic [13:0]        rem100;
  logic [4:0]         w_len, b_len;
  logic signed [14:0] w_len_s, b_len_s;
  logic [3:0]         f_m, b_m;
  logic [13:0]        f_y, b_y;
  logic [6:0]         f_yy, f_cc, b_yy, b_cc;
  logic               fwd_go, back_go, w_valid, delta_bad;
  logic signed [17:0] delta_ext;
  logic [6:0]         zk, zj;
  logic [9:0]         zsum;

  // Year split for a load: quotient by reciprocal, remainder by subtract
  assign prod100 = 27'(ld_yr_q) * 27'(Div100Mul);
  assign rem100  = ld_yr_q - 14'(q100_q) * 14'd100;

  // Length of the working month
  assign w_len   = month_len(wm_q, is_leap(wy_q[1:0], wyy_q, wcc_q));
  assign w_len_s = $signed({10'd0, w_len});

  // Next month forward
  always_comb begin
    f_m  = wm_q + 4'd1;
    f_y  = wy_q;
    f_yy = wyy_q;
    f_cc = wcc_q;
    if (wm_q == 4'd12) begin
      f_m = 4'd1;
      f_y = wy_q + 14'd1;
      if (wyy_q == 7'd99) begin
        f_yy = 7'd0;
        f_cc = wcc_q + 7'd1;
      end else begin
        f_yy = wyy_q + 7'd1;
      end
    end
  end

  // Previous month
  always_comb begin
    b_m  = wm_q - 4'd1;
    b_y  = wy_q;
    b_yy = wyy_q;
    b_cc = wcc_q;
    if (wm_q == 4'd1) begin
      b_m = 4'd12;
      b_y = wy_q - 14'd1;
      if (wyy_q == 7'd0) begin
        b_yy = 7'd99;
        b_cc = wcc_q - 7'd1;
      end else begin
        b_yy = wyy_q - 7'd1;
      end
    end
  end

  assign b_len   = month_len(b_m, is_leap(b_y[1:0], b_yy, b_cc));
  assign b_len_s = $signed({10'd0, b_len});

  // Walk conditions, one month per step
  assign fwd_go  = !delta_q[13] && (wd_q > w_len_s) && (wy_q <= YearMax);
  assign back_go = delta_q[13] && (wd_q <= 15'sd0) && (wy_q >= YearMin);

  assign delta_ext = $signed({{4{delta_q[13]}}, delta_q});
  assign delta_bad = (delta_ext > $signed(18'(MaxDelta))) ||
                     (delta_ext < -$signed(18'(MaxDelta)));

  assign w_valid = (wy_q >= YearMin) && (wy_q <= YearMax) &&
                   (wm_q >= 4'd1) && (wm_q <= 4'd12) &&
                   (wd_q >= 15'sd1) && (wd_q <= w_len_s);

  assign stat_o.walk_done = !(fwd_go || back_go);
  assign stat_o.delta_bad = delta_bad;

  // Zeller terms: January and February count in the previous year
  always_comb begin
    zk = cur_yy_q;
    zj = cur_cc_q;
    if (cur_mon_q < 4'd3) begin
      if (cur_yy_q == 7'd0) begin
        zk = 7'd99;
        zj = cur_cc_q - 7'd1;
      end else begin
        zk = cur_yy_q - 7'd1;
      end
    end
  end

  assign zsum = 10'(cur_day_q) + 10'(zeller_mterm(cur_mon_q)) + 10'(zk) +
                10'(zk[6:2]) + 10'(zj[6:2]) + WdayBias - 10'({zj, 1'b0});

  // Request capture and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ld_day_q <= load_day_i;
      ld_mon_q <= load_month_i;
      ld_yr_q  <= load_year_i;
      delta_q  <= day_delta_i;
    end
    if (cmd_i.load_div) begin
      q100_q <= prod100[Div100Shift +: 8];
      wd_q   <= $signed({10'd0, ld_day_q});
      wm_q   <= ld_mon_q;
      wy_q   <= ld_yr_q;
    end
    if (cmd_i.load_rem) begin
      wyy_q <= rem100[6:0];
      wcc_q <= q100_q[6:0];
    end
    if (cmd_i.add_init) begin
      wd_q  <= $signed({10'd0, cur_day_q}) + $signed({delta_q[13], delta_q});
      wm_q  <= cur_mon_q;
      wy_q  <= cur_yr_q;
      wyy_q <= cur_yy_q;
      wcc_q <= cur_cc_q;
      ok_q  <= !delta_bad;
    end
    if (cmd_i.walk) begin
      if (fwd_go) begin
        wd_q  <= wd_q - w_len_s;
        wm_q  <= f_m;
        wy_q  <= f_y;
        wyy_q <= f_yy;
        wcc_q <= f_cc;
      end else if (back_go) begin
        wd_q  <= wd_q + b_len_s;
        wm_q  <= b_m;
        wy_q  <= b_y;
        wyy_q <= b_yy;
        wcc_q <= b_cc;
      end
    end
    if (cmd_i.check) begin
      ok_q <= w_valid;
    end
    if (cmd_i.wday) begin
      wx_q <= zsum[8:0];
    end
    if (cmd_i.out_load) begin
      rsp_ok_q   <= ok_q;
      rsp_day_q  <= cur_day_q;
      rsp_mon_q  <= cur_mon_q;
      rsp_yr_q   <= cur_yr_q;
      rsp_wday_q <= mod7(wx_q);
    end
  end

  // Held date, committed only when the checked date is valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_day_q <= ResetDay;
      cur_mon_q <= ResetMon;
      cur_yr_q  <= YearMin;
      cur_yy_q  <= ResetYy;
      cur_cc_q  <= ResetCc;
    end else if (cmd_i.check && w_valid) begin
      cur_day_q <= wd_q[4:0];
      cur_mon_q <= wm_q;
      cur_yr_q  <= wy_q;
      cur_yy_q  <= wyy_q;
      cur_cc_q  <= wcc_q;
    end
  end

  assign ok_o        = rsp_ok_q;
  assign out_day_o   = rsp_day_q;
  assign out_month_o = rsp_mon_q;
  assign out_year_o  = rsp_yr_q;
  assign weekday_o   = rsp_wday_q;

  `CDS_ASSERT_ALWAYS(a_year_range, (cur_yr_q >= YearMin) && (cur_yr_q <= YearMax), "held year out of range")
  `CDS_ASSERT_ALWAYS(a_year_split, cur_yr_q == 14'(cur_cc_q) * 14'd100 + 14'(cur_yy_q), "century split out of step with year")
  `CDS_ASSERT_ALWAYS(a_day_fits, (cur_day_q >= 5'd1) && (cur_day_q <= month_len(cur_mon_q, is_leap(cur_yr_q[1:0], cur_yy_q, cur_cc_q))), "held day beyond month length")

endmodule

### rtl/calendar_date_stepper.sv
// A load, once accepted, steps through LOAD_DIV, LOAD_REM, CHECK, WDAY and DONE; an add
// steps through ADD_INIT, WALK (one month boundary per cycle, up to about 135 in all),
// CHECK, WDAY and DONE; an add with an oversized delta skips the walk and the check.
// Only one transaction is in flight: a new request is taken once DONE has loaded the
// response register, and DONE waits while a pending response is not yet taken.
// Reset (rst_ni, asynchronous, active low) sets the date to 1 January 1900 and
// empties the response register.
module calendar_date_stepper (
  input  logic       clk_i,
  input  logic       rst_ni,
  cds_req_if.sink    req_i,
  cds_rsp_if.source  rsp_o
);
  import cds_pkg::*;

  cds_cmd_t  cmd;
  cds_stat_t stat;

  cds_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (req_i.valid),
    .in_req_type_i (req_i.req_type),
    .in_ready_o    (req_i.ready),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  cds_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .load_day_i   (req_i.load_day),
    .load_month_i (req_i.load_month),
    .load_year_i  (req_i.load_year),
    .day_delta_i  (req_i.day_delta),
    .ok_o         (rsp_o.ok),
    .out_day_o    (rsp_o.out_day),
    .out_month_o  (rsp_o.out_month),
    .out_year_o   (rsp_o.out_year),
    .weekday_o    (rsp_o.weekday)
  );

endmodule

### dv/tb.sv
// Self-checking testbench for the calendar date stepper: directed and random load/add traffic.
module tb;
  import cds_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int TailCycles = 160;
  localparam int RandItems  = 650;

  // One request transaction as queued for the driver
  typedef struct {
    cds_req_e           kind;
    logic [4:0]         day;
    logic [3:0]         month;
    logic [13:0]        year;
    logic signed [13:0] delta;
    bit                 drain;
  } date_req_t;

  // Expected response transaction
  typedef struct {
    logic        ok;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  wday;
  } date_rsp_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  cds_req_if req_if ();
  cds_rsp_if rsp_if ();

  calendar_date_stepper u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  date_req_t req_queue[$];
  date_rsp_t expected_dates[$];
  date_req_t drv_item;
  date_rsp_t rsp_want;

  // Predicted calendar state
  int cal_day   = 1;
  int cal_month = 1;
  int cal_year  = 1900;

  int sent_cnt   = 0;
  int got_cnt    = 0;
  int cycle_cnt  = 0;
  int hold_left  = 0;
  int err_cnt    = 0;
  bit hold_done  = 1'b0;
  bit drain_next = 1'b0;

  always #2 clk = ~clk;

  // Calendar helpers for the predictor
  function automatic int days_in_month(int m, int y);
    bit leap;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    case (m)
      2:           return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic bit date_ok(int d, int m, int y);
    if (y < int'(YearMin) || y > int'(YearMax) || m < 1 || m > 12 || d < 1) return 1'b0;
    return d <= days_in_month(m, y);
  endfunction

  // Zeller's congruence, truncating division, folded to a non-negative weekday
  function automatic logic [2:0] zeller_weekday(int d, int m, int y);
    int k, j, f;
    if (m < 3) begin
      m += 12;
      y -= 1;
    end
    k = y % 100;
    j = y / 100;
    f = d + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 - 2 * j;
    f = (f + 5) % 7;
    if (f < 0) f += 7;
    return 3'(f);
  endfunction

  // Month-by-month walk; the date changes only when the result is in range
  function automatic bit walk_days(int delta);
    int d, m, y;
    d = cal_day + delta;
    m = cal_month;
    y = cal_year;
    if (delta > 0) begin
      while (d > days_in_month(m, y) && y <= int'(YearMax)) begin
        d -= days_in_month(m, y);
        if (m == 12) begin
          m = 1;
          y++;
        end else begin
          m++;
        end
      end
    end else if (delta < 0) begin
      while (d <= 0 && y >= int'(YearMin)) begin
        if (m == 1) begin
          m = 12;
          y--;
        end else begin
          m--;
        end
        d += days_in_month(m, y);
      end
    end
    if (!date_ok(d, m, y)) return 1'b0;
    cal_day   = d;
    cal_month = m;
    cal_year  = y;
    return 1'b1;
  endfunction

  function automatic date_rsp_t step_calendar(date_req_t it);
    date_rsp_t r;
    int        delta;
    if (it.kind == REQ_LOAD) begin
      r.ok = date_ok(it.day, it.month, it.year);
      if (r.ok) begin
        cal_day   = it.day;
        cal_month = it.month;
        cal_year  = it.year;
      end
    end else begin
      delta = it.delta;
      if (delta > MaxDelta || delta < -MaxDelta) r.ok = 1'b0;
      else r.ok = walk_days(delta);
    end
    r.day   = 5'(cal_day);
    r.month = 4'(cal_month);
    r.year  = 14'(cal_year);
    r.wday  = zeller_weekday(cal_day, cal_month, cal_year);
    return r;
  endfunction

  // Stimulus builders; unused payload fields get random content
  task automatic queue_load(int d, int m, int y);
    date_req_t it;
    it.kind    = REQ_LOAD;
    it.day     = 5'(d);
    it.month   = 4'(m);
    it.year    = 14'(y);
    it.delta   = 14'($urandom);
    it.drain   = drain_next;
    drain_next = 1'b0;
    req_queue.push_back(it);
  endtask

  task automatic queue_add(int delta);
    date_req_t it;
    it.kind    = REQ_ADD;
    it.day     = 5'($urandom);
    it.month   = 4'($urandom);
    it.year    = 14'($urandom);
    it.delta   = 14'(delta);
    it.drain   = drain_next;
    drain_next = 1'b0;
    req_queue.push_back(it);
  endtask

  function automatic void report_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endfunction

  // Request driver: predicts each accepted transaction, then offers the next one
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_dates.push_back(step_calendar(drv_item));
        sent_cnt <= sent_cnt + 1;
      end
      if (!(req_if.valid && !req_if.ready)) begin
        if (req_queue.size() == 0 ||
            (($urandom_range(99) < 28) && !(sent_cnt >= 250 && sent_cnt < 380)) ||
            (req_queue[0].drain && expected_dates.size() != 0)) begin
          req_if.valid <= 1'b0;
        end else begin
          drv_item = req_queue.pop_front();
          req_if.valid      <= 1'b1;
          req_if.req_type   <= drv_item.kind;
          req_if.load_day   <= drv_item.day;
          req_if.load_month <= drv_item.month;
          req_if.load_year  <= drv_item.year;
          req_if.day_delta  <= drv_item.delta;
        end
      end
    end
  end

  // Long receiver hold-off, once, while the sender keeps offering
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_cnt >= 150) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  // Response monitor and checker
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got_cnt <= got_cnt + 1;
        if (expected_dates.size() == 0) begin
          report_error($sformatf("tb: response with no pending request, date %0d-%0d-%0d",
                                 rsp_if.out_year, rsp_if.out_month, rsp_if.out_day));
        end else begin
          rsp_want = expected_dates.pop_front();
          if (rsp_want.ok !== rsp_if.ok || rsp_want.day !== rsp_if.out_day ||
              rsp_want.month !== rsp_if.out_month || rsp_want.year !== rsp_if.out_year ||
              rsp_want.wday !== rsp_if.weekday) begin
            report_error($sformatf(
              "tb: mismatch #%0d exp ok=%0b %0d-%0d-%0d wd=%0d got ok=%0b %0d-%0d-%0d wd=%0d",
              got_cnt, rsp_want.ok, rsp_want.year, rsp_want.month, rsp_want.day,
              rsp_want.wday, rsp_if.ok, rsp_if.out_year, rsp_if.out_month,
              rsp_if.out_day, rsp_if.weekday));
          end
        end
      end
      rsp_if.ready <= (hold_left == 0) &&
                      ((got_cnt >= 250 && got_cnt < 380) || ($urandom_range(99) >= 28));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin : stim
    int  y, m, n, steps, pick, sel;
    bit  mid_drain;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_LOAD;
    req_if.load_day   = '0;
    req_if.load_month = '0;
    req_if.load_year  = '0;
    req_if.day_delta  = '0;
    rsp_if.ready      = 1'b0;
    mid_drain         = 1'b0;

    // Directed: zero delta, range exits, oversized deltas, leap rule, bad fields
    queue_add(0);
    queue_add(-1);
    queue_load(31, 12, 9999);
    queue_add(1);
    queue_add(-4096);
    queue_add(4096);
    queue_add(4097);
    queue_add(-4097);
    queue_add(-8192);
    queue_add(8191);
    queue_load(29, 2, 1900);
    drain_next = 1'b1;
    queue_load(29, 2, 2000);
    queue_load(29, 2, 2100);
    queue_load(29, 2, 2024);
    queue_load(0, 5, 2000);
    queue_load(31, 4, 2000);
    queue_load(10, 0, 2000);
    queue_load(10, 13, 2000);
    queue_load(31, 15, 16383);
    queue_load(1, 1, 1899);
    queue_load(1, 1, 10000);
    queue_load(1, 1, 1900);
    queue_add(-4096);
    queue_load(28, 2, 2023);
    queue_add(1);
    queue_load(1, 3, 2024);
    queue_add(-1);

    // Random: mostly a valid load followed by a run of adds, plus noise
    n = 0;
    while (n < RandItems) begin
      if (n >= RandItems / 2 && !mid_drain) begin
        drain_next = 1'b1;
        mid_drain  = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        sel = $urandom_range(9);
        if (sel < 2) y = $urandom_range(1912, 1900);
        else if (sel < 4) y = $urandom_range(9999, 9988);
        else y = $urandom_range(9999, 1900);
        m = $urandom_range(12, 1);
        queue_load($urandom_range(days_in_month(m, y), 1), m, y);
        n++;
        steps = $urandom_range(6, 1);
        repeat (steps) begin
          sel = $urandom_range(99);
          if (sel < 5) queue_add(0);
          else if (sel < 45) queue_add(int'($urandom_range(80)) - 40);
          else if (sel < 70) queue_add(int'($urandom_range(800)) - 400);
          else queue_add(int'($urandom_range(8192)) - 4096);
          n++;
        end
      end else if (pick < 85) begin
        if ($urandom_range(1)) begin
          queue_load($urandom_range(31), $urandom_range(15), $urandom_range(16383));
        end else begin
          y = $urandom_range(9999, 1900);
          m = $urandom_range(12, 1);
          queue_load(days_in_month(m, y) + 1, m, y);
        end
        n++;
      end else begin
        queue_add(int'($urandom_range(16383)) - 8192);
        n++;
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (req_queue.size() != 0 || req_if.valid) @(posedge clk);
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (err_cnt == 0 && expected_dates.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
